// File: rtl/expiring_slot_allocator_defines.svh
// Assertion macros shared by the expiring slot allocator RTL.
`ifndef EXPIRING_SLOT_ALLOCATOR_DEFINES_SVH
`define EXPIRING_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ESA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/esa_pkg.sv
// Package with types, constants and helpers of the expiring slot allocator.
`timescale 1ns / 1ps

package esa_pkg;

    localparam int SLOTS_DEFAULT      = 4;
    localparam int CURSOR_RESET_LIMIT = 4;
    localparam int TIME_W             = 31;
    localparam int DELTA_W            = 16;
    localparam int BYTE_W             = 8;
    localparam int MODE_W             = 2;
    localparam int SLOT_OUT_W         = 2;

    localparam logic [DELTA_W-1:0] DEFAULT_DURATION_RESET = 16'd70;

    localparam logic [MODE_W-1:0] MODE_DISCARD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SMALLEST = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_END,
        S_SCAN,
        S_DECIDE
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] val;
        logic [BYTE_W-1:0] kind;
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_end;
    } slot_t;

    function automatic logic [TIME_W-1:0] sat_add(
        input logic [TIME_W-1:0]  a,
        input logic [DELTA_W-1:0] b
    );
        logic [TIME_W:0] s;
        begin
            s = {1'b0, a} + {{(TIME_W + 1 - DELTA_W){1'b0}}, b};
            sat_add = s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
        end
    endfunction

endpackage

// File: rtl/expiring_slot_allocator.sv
// An accepted request computes its start tick, then its end tick, then scans the slots
// and decides; no new request is taken until the result is registered. The slot store's
// single read port is scanned one slot per cycle over the effective limit.
// Reset: all slots read as empty through per-slot valid bits, default duration is 70,
// the output register is empty and the block is ready for a request at once.
`timescale 1ns / 1ps
`include "expiring_slot_allocator_defines.svh"

module expiring_slot_allocator #(
    parameter int SLOTS = esa_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [esa_pkg::DELTA_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [esa_pkg::TIME_W-1:0]    now_cycle,
    input  logic [esa_pkg::BYTE_W-1:0]    entry_type,
    input  logic [esa_pkg::BYTE_W-1:0]    entry_value,
    input  logic [esa_pkg::DELTA_W-1:0]   start_delay,
    input  logic [esa_pkg::BYTE_W-1:0]    limit_request,
    input  logic [esa_pkg::DELTA_W-1:0]   lifetime,
    input  logic [esa_pkg::MODE_W-1:0]    mode,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          accepted,
    output logic [esa_pkg::SLOT_OUT_W-1:0] slot_written,
    output logic [esa_pkg::TIME_W-1:0]    end_time
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);

    esa_pkg::state_t state_reg, state_next;

    esa_pkg::slot_t mem [SLOTS];
    logic [SLOTS-1:0] vld_reg;

    logic [esa_pkg::DELTA_W-1:0] dflt_reg;

    logic [esa_pkg::TIME_W-1:0]  now_reg;
    logic [esa_pkg::BYTE_W-1:0]  typ_reg;
    logic [esa_pkg::BYTE_W-1:0]  val_reg;
    logic [esa_pkg::DELTA_W-1:0] delay_reg;
    logic [esa_pkg::DELTA_W-1:0] life_reg;
    logic [esa_pkg::MODE_W-1:0]  mode_reg;
    logic [LW-1:0]               limit_reg;
    logic [esa_pkg::TIME_W-1:0]  start_reg;
    logic [esa_pkg::TIME_W-1:0]  end_reg;

    logic [LW-1:0]  rd_cnt_reg;
    logic           chk_vld_reg;
    logic [IW-1:0]  chk_idx_reg;
    esa_pkg::slot_t rd_word_reg;
    logic           rd_ok_reg;

    logic                        any_free_reg;
    logic [IW-1:0]               first_free_reg;
    logic                        any_live_reg;
    logic [IW-1:0]               last_live_reg;
    logic [esa_pkg::BYTE_W-1:0]  min_val_reg;
    logic [IW-1:0]               min_val_idx_reg;
    logic [esa_pkg::TIME_W-1:0]  min_end_reg;
    logic [IW-1:0]               min_end_idx_reg;

    logic                            out_valid_reg;
    logic                            accepted_reg;
    logic [esa_pkg::SLOT_OUT_W-1:0]  slot_reg;
    logic [esa_pkg::TIME_W-1:0]      end_out_reg;

    logic                        in_fire;
    logic                        rd_issue;
    logic                        scan_last;
    logic                        decide_fire;
    logic [LW-1:0]               limit_eff;
    logic [IW-1:0]               rd_idx;
    logic [esa_pkg::TIME_W-1:0]  e_end;
    logic [esa_pkg::BYTE_W-1:0]  e_val;
    logic                        e_live;
    logic                        e_first;
    logic [esa_pkg::BYTE_W-1:0]  next_after;
    logic                        use_after;
    logic                        do_write;
    logic [IW-1:0]               chosen;
    esa_pkg::slot_t              wr_word;

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign slot_written = slot_reg;
    assign end_time     = end_out_reg;

    always_comb
    begin
        if (limit_request == '0 || limit_request > esa_pkg::BYTE_W'(SLOTS))
        begin
            limit_eff = LW'(SLOTS);
        end
        else
        begin
            limit_eff = limit_request[LW-1:0];
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            esa_pkg::S_IDLE:   if (in_valid) state_next = esa_pkg::S_START;
            esa_pkg::S_START:  state_next = esa_pkg::S_END;
            esa_pkg::S_END:    state_next = esa_pkg::S_SCAN;
            esa_pkg::S_SCAN:   if (scan_last) state_next = esa_pkg::S_DECIDE;
            esa_pkg::S_DECIDE: if (decide_fire) state_next = esa_pkg::S_IDLE;
            default:           state_next = esa_pkg::S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_stall    = 1'b1;
        rd_issue    = 1'b0;
        decide_fire = 1'b0;
        case (state_reg)
            esa_pkg::S_IDLE:   in_stall = 1'b0;
            esa_pkg::S_SCAN:   rd_issue = (rd_cnt_reg < limit_reg);
            esa_pkg::S_DECIDE: decide_fire = !out_valid_reg || !out_stall;
            default:           in_stall = 1'b1;
        endcase
    end

    assign in_fire   = in_valid && !in_stall;
    assign rd_idx    = rd_cnt_reg[IW-1:0];
    assign scan_last = chk_vld_reg && (LW'(chk_idx_reg) == limit_reg - LW'(1));

    assign e_end   = rd_ok_reg ? rd_word_reg.t_end : '0;
    assign e_val   = rd_ok_reg ? rd_word_reg.val : '0;
    assign e_live  = e_end > now_reg;
    assign e_first = (chk_idx_reg == '0);

    // Pick after the last live slot if it is in a limit <= 4, else the first free slot.
    always_comb
    begin
        next_after = esa_pkg::BYTE_W'(last_live_reg) + esa_pkg::BYTE_W'(1);
        use_after  = any_live_reg && (next_after < esa_pkg::BYTE_W'(limit_reg))
                  && (esa_pkg::BYTE_W'(limit_reg) <= esa_pkg::BYTE_W'(esa_pkg::CURSOR_RESET_LIMIT));
        do_write   = 1'b1;
        chosen     = first_free_reg;
        if (any_free_reg)
        begin
            if (use_after)
            begin
                chosen = next_after[IW-1:0];
            end
        end
        else
        begin
            case (mode_reg)
                esa_pkg::MODE_DISCARD:
                begin
                    do_write = 1'b0;
                end
                esa_pkg::MODE_SMALLEST:
                begin
                    chosen   = min_val_idx_reg;
                    do_write = (min_val_reg < val_reg);
                end
                default:
                begin
                    chosen = min_end_idx_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        wr_word.val     = val_reg;
        wr_word.kind    = typ_reg;
        wr_word.t_start = start_reg;
        wr_word.t_end   = end_reg;
    end

    always_ff @(posedge clk)
    begin
        if (decide_fire && do_write)
        begin
            mem[chosen] <= wr_word;
        end
        if (rd_issue)
        begin
            rd_word_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= esa_pkg::S_IDLE;
            vld_reg       <= '0;
            dflt_reg      <= esa_pkg::DEFAULT_DURATION_RESET;
            rd_cnt_reg    <= '0;
            chk_vld_reg   <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                dflt_reg <= cfg_data;
            end
            if (in_fire)
            begin
                rd_cnt_reg <= '0;
            end
            else if (rd_issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + LW'(1);
            end
            chk_vld_reg <= rd_issue;
            if (rd_issue)
            begin
                rd_ok_reg <= vld_reg[rd_idx];
            end
            if (decide_fire && do_write)
            begin
                vld_reg[chosen] <= 1'b1;
            end
            if (decide_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            now_reg   <= now_cycle;
            typ_reg   <= entry_type;
            val_reg   <= entry_value;
            delay_reg <= start_delay;
            life_reg  <= (lifetime == '0) ? dflt_reg : lifetime;
            mode_reg  <= mode;
            limit_reg <= limit_eff;
        end
        if (state_reg == esa_pkg::S_START)
        begin
            start_reg <= esa_pkg::sat_add(now_reg, delay_reg);
        end
        if (state_reg == esa_pkg::S_END)
        begin
            end_reg <= esa_pkg::sat_add(start_reg, life_reg);
        end
        if (rd_issue)
        begin
            chk_idx_reg <= rd_idx;
        end
        if (chk_vld_reg)
        begin
            if (e_first)
            begin
                any_free_reg    <= !e_live;
                first_free_reg  <= '0;
                any_live_reg    <= e_live;
                last_live_reg   <= '0;
                min_val_reg     <= e_val;
                min_val_idx_reg <= '0;
                min_end_reg     <= e_end;
                min_end_idx_reg <= '0;
            end
            else
            begin
                if (!e_live && !any_free_reg)
                begin
                    any_free_reg   <= 1'b1;
                    first_free_reg <= chk_idx_reg;
                end
                if (e_live)
                begin
                    any_live_reg  <= 1'b1;
                    last_live_reg <= chk_idx_reg;
                end
                if (e_val < min_val_reg)
                begin
                    min_val_reg     <= e_val;
                    min_val_idx_reg <= chk_idx_reg;
                end
                if (e_end < min_end_reg)
                begin
                    min_end_reg     <= e_end;
                    min_end_idx_reg <= chk_idx_reg;
                end
            end
        end
        if (decide_fire)
        begin
            accepted_reg <= do_write;
            slot_reg     <= do_write ? esa_pkg::SLOT_OUT_W'(chosen) : '0;
            end_out_reg  <= do_write ? end_reg : '0;
        end
    end

    `ESA_ASSERT_NEXT(a_write_gives_accept, decide_fire && do_write, out_valid && accepted, "store write without an accepted result")
    `ESA_ASSERT_NOW(a_drop_zero_fields, out_valid && !accepted, slot_written == '0 && end_time == '0, "dropped request carries nonzero fields")
    `ESA_ASSERT_NOW(a_scan_in_limit, chk_vld_reg, LW'(chk_idx_reg) < limit_reg, "scanned slot beyond the limit")
    `ESA_ASSERT_NEXT(a_request_starts, in_fire, state_reg == esa_pkg::S_START && rd_cnt_reg == '0, "accepted request did not start a scan")

endmodule

// File: dv/expiring_slot_allocator_tb.sv
// Self-checking testbench for the expiring slot allocator with directed and random requests.
`timescale 1ns / 1ps

module expiring_slot_allocator_tb;

    localparam int TABLE_SLOTS = esa_pkg::SLOTS_DEFAULT;
    localparam int SETTLE_CYCLES = TABLE_SLOTS + 8;
    localparam logic [esa_pkg::TIME_W-1:0] TIME_MAX = {esa_pkg::TIME_W{1'b1}};
    localparam logic [esa_pkg::MODE_W-1:0] MODE_EARLIEST = 2'd2;
    localparam logic [esa_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [esa_pkg::TIME_W-1:0]  now_tick;
        logic [esa_pkg::BYTE_W-1:0]  kind;
        logic [esa_pkg::BYTE_W-1:0]  value;
        logic [esa_pkg::DELTA_W-1:0] delay;
        logic [esa_pkg::BYTE_W-1:0]  limit;
        logic [esa_pkg::DELTA_W-1:0] life;
        logic [esa_pkg::MODE_W-1:0]  policy;
    } alloc_req_t;

    typedef struct packed {
        logic                           written;
        logic [esa_pkg::SLOT_OUT_W-1:0] slot;
        logic [esa_pkg::TIME_W-1:0]     t_end;
    } alloc_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [esa_pkg::DELTA_W-1:0]      cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [esa_pkg::TIME_W-1:0]       now_cycle = '0;
    logic [esa_pkg::BYTE_W-1:0]       entry_type = '0;
    logic [esa_pkg::BYTE_W-1:0]       entry_value = '0;
    logic [esa_pkg::DELTA_W-1:0]      start_delay = '0;
    logic [esa_pkg::BYTE_W-1:0]       limit_request = '0;
    logic [esa_pkg::DELTA_W-1:0]      lifetime = '0;
    logic [esa_pkg::MODE_W-1:0]       mode = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             accepted;
    logic [esa_pkg::SLOT_OUT_W-1:0]   slot_written;
    logic [esa_pkg::TIME_W-1:0]       end_time;

    // Mirror of the slot table and the duration register.
    logic [esa_pkg::BYTE_W-1:0]  tbl_value [TABLE_SLOTS] = '{default: '0};
    logic [esa_pkg::BYTE_W-1:0]  tbl_kind [TABLE_SLOTS] = '{default: '0};
    logic [esa_pkg::TIME_W-1:0]  tbl_start [TABLE_SLOTS] = '{default: '0};
    logic [esa_pkg::TIME_W-1:0]  tbl_end [TABLE_SLOTS] = '{default: '0};
    logic [esa_pkg::DELTA_W-1:0] duration_reg = esa_pkg::DEFAULT_DURATION_RESET;

    alloc_result_t pending_results [$];

    int fail_count = 0;
    int n_requests = 0;
    int n_written = 0;
    int n_dropped = 0;
    int n_cfg_writes = 0;
    int unsigned burst_left = 0;
    int unsigned stall_pct = 0;
    int unsigned stall_left = 0;
    bit stall_now = 1'b0;
    logic [esa_pkg::TIME_W-1:0] tick_now = '0;

    expiring_slot_allocator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .now_cycle    (now_cycle),
        .entry_type   (entry_type),
        .entry_value  (entry_value),
        .start_delay  (start_delay),
        .limit_request(limit_request),
        .lifetime     (lifetime),
        .mode         (mode),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .slot_written (slot_written),
        .end_time     (end_time)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [esa_pkg::TIME_W-1:0] add_clamped(
        input logic [esa_pkg::TIME_W-1:0] a,
        input logic [esa_pkg::TIME_W-1:0] b);
        logic [esa_pkg::TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[esa_pkg::TIME_W] ? TIME_MAX : s[esa_pkg::TIME_W-1:0];
    endfunction

    // Picks a slot for the request, updates the table mirror and returns the result.
    function automatic alloc_result_t allocate_slot(input alloc_req_t r);
        alloc_result_t               res;
        int unsigned                 span;
        int unsigned                 cursor;
        int unsigned                 probe;
        int unsigned                 pick;
        logic [esa_pkg::DELTA_W-1:0] life;
        logic [esa_pkg::TIME_W-1:0]  t_start;
        logic [esa_pkg::TIME_W-1:0]  t_end;
        logic [esa_pkg::TIME_W-1:0]  metric;
        logic [esa_pkg::TIME_W-1:0]  best;
        bit                          full;
        bit                          found;
        res = '0;
        cursor = 0;
        pick = 0;
        best = '0;
        full = 1'b1;
        found = 1'b0;
        span = (r.limit == 0 || r.limit > TABLE_SLOTS) ? TABLE_SLOTS : int'(r.limit);
        life = (r.life == 0) ? duration_reg : r.life;
        t_start = add_clamped(r.now_tick,
                              {{(esa_pkg::TIME_W-esa_pkg::DELTA_W){1'b0}}, r.delay});
        t_end = add_clamped(t_start, {{(esa_pkg::TIME_W-esa_pkg::DELTA_W){1'b0}}, life});
        for (int i = 0; i < span; i++)
        begin
            if (tbl_end[i] > r.now_tick)
                cursor = (i + 1) % span;
            else
                full = 1'b0;
        end
        if (span > esa_pkg::CURSOR_RESET_LIMIT)
            cursor = 0;
        if (!full)
        begin
            for (int i = 0; i < span; i++)
            begin
                probe = cursor;
                cursor = (cursor + 1) % span;
                if (!found && tbl_end[probe] <= r.now_tick)
                begin
                    pick = probe;
                    found = 1'b1;
                end
            end
        end
        else
        begin
            if (r.policy == esa_pkg::MODE_DISCARD)
                return res;
            for (int i = 0; i < span; i++)
            begin
                metric = (r.policy == esa_pkg::MODE_SMALLEST) ?
                         {{(esa_pkg::TIME_W-esa_pkg::BYTE_W){1'b0}}, tbl_value[i]} :
                         tbl_end[i];
                if (i == 0 || metric < best)
                begin
                    best = metric;
                    pick = i;
                end
            end
            found = 1'b1;
            if (r.policy == esa_pkg::MODE_SMALLEST && best >= r.value)
                return res;
        end
        if (!found)
            return res;
        tbl_value[pick] = r.value;
        tbl_kind[pick] = r.kind;
        tbl_start[pick] = t_start;
        tbl_end[pick] = t_end;
        res.written = 1'b1;
        res.slot = pick[esa_pkg::SLOT_OUT_W-1:0];
        res.t_end = t_end;
        return res;
    endfunction

    function automatic alloc_req_t pack_request(
        input logic [esa_pkg::TIME_W-1:0]  now_tick,
        input logic [esa_pkg::BYTE_W-1:0]  kind,
        input logic [esa_pkg::BYTE_W-1:0]  value,
        input logic [esa_pkg::DELTA_W-1:0] delay,
        input logic [esa_pkg::BYTE_W-1:0]  limit,
        input logic [esa_pkg::DELTA_W-1:0] life,
        input logic [esa_pkg::MODE_W-1:0]  policy);
        alloc_req_t r;
        r.now_tick = now_tick;
        r.kind = kind;
        r.value = value;
        r.delay = delay;
        r.limit = limit;
        r.life = life;
        r.policy = policy;
        return r;
    endfunction

    // Most requests follow a slowly advancing clock so that entries live and expire;
    // a few jump anywhere or land near the top of the tick range.
    function automatic alloc_req_t random_request();
        alloc_req_t  r;
        int unsigned pick;
        int unsigned advance;
        pick = $urandom_range(99);
        advance = $urandom_range(40);
        if (pick < 3)
            tick_now = esa_pkg::TIME_W'($urandom);
        else if (pick < 5)
            tick_now = TIME_MAX - esa_pkg::TIME_W'($urandom_range(300));
        else if (tick_now > TIME_MAX - esa_pkg::TIME_W'(advance))
            tick_now = esa_pkg::TIME_W'($urandom_range(1000));
        else
            tick_now = tick_now + esa_pkg::TIME_W'(advance);
        r.now_tick = tick_now;
        r.kind = esa_pkg::BYTE_W'($urandom_range(255));
        r.value = esa_pkg::BYTE_W'($urandom_range(255));
        r.delay = ($urandom_range(99) < 80) ? esa_pkg::DELTA_W'($urandom_range(20)) :
                                              esa_pkg::DELTA_W'($urandom_range(65535));
        pick = $urandom_range(99);
        if (pick < 70)
            r.limit = esa_pkg::BYTE_W'($urandom_range(TABLE_SLOTS, 1));
        else if (pick < 85)
            r.limit = '0;
        else
            r.limit = esa_pkg::BYTE_W'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 15)
            r.life = '0;
        else if (pick < 80)
            r.life = esa_pkg::DELTA_W'($urandom_range(150, 1));
        else
            r.life = esa_pkg::DELTA_W'($urandom_range(65535));
        r.policy = esa_pkg::MODE_W'($urandom_range(3));
        return r;
    endfunction

    // The sender works in bursts; a gap of random length opens each new burst.
    task automatic send_request(input alloc_req_t r);
        alloc_result_t due;
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(11)) @(negedge clk);
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(60, 25) :
                         $urandom_range(12, 1);
        end
        @(negedge clk);
        now_cycle <= r.now_tick;
        entry_type <= r.kind;
        entry_value <= r.value;
        start_delay <= r.delay;
        limit_request <= r.limit;
        lifetime <= r.life;
        mode <= r.policy;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        due = allocate_slot(r);
        pending_results.push_back(due);
        n_requests++;
        if (due.written)
            n_written++;
        else
            n_dropped++;
        burst_left--;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_duration(input logic [esa_pkg::DELTA_W-1:0] value);
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        duration_reg = value;
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        stall_pct = 40;
        send_request(pack_request(0, 8'h00, 8'h00, 0, 0, 0, esa_pkg::MODE_DISCARD));
        send_request(pack_request(10, 8'h01, 8'd200, 0, 4, 1000, esa_pkg::MODE_DISCARD));
        send_request(pack_request(10, 8'h02, 8'd30, 0, 4, 1000, esa_pkg::MODE_DISCARD));
        send_request(pack_request(10, 8'h03, 8'd90, 0, 4, 1000, esa_pkg::MODE_DISCARD));
        // The table is full for the next five requests, so the mode decides.
        send_request(pack_request(20, 8'hAA, 8'h55, 0, 4, 5, esa_pkg::MODE_DISCARD));
        send_request(pack_request(20, 8'h55, 8'h00, 0, 4, 5, esa_pkg::MODE_SMALLEST));
        send_request(pack_request(20, 8'h5A, 8'hFF, 0, 4, 5, esa_pkg::MODE_SMALLEST));
        send_request(pack_request(20, 8'hA5, 8'h01, 0, 4, 5, MODE_EARLIEST));
        send_request(pack_request(21, 8'h0F, 8'h02, 0, 4, 5, MODE_SPARE));
        send_request(pack_request(30, 8'hF0, 8'h03, 0, 8'hFF, 5, esa_pkg::MODE_DISCARD));
        send_request(pack_request(30, 8'h11, 8'h04, 0, 1, 9, MODE_EARLIEST));
        send_request(pack_request(30, 8'h22, 8'd250, 0, 2, 9, esa_pkg::MODE_SMALLEST));
        send_request(pack_request(30, 8'h33, 8'h05, 0, 3, 9, esa_pkg::MODE_DISCARD));
        send_request(pack_request(2000, 8'hFF, 8'hFF, 16'hFFFF, 4, 16'hFFFF,
                                  esa_pkg::MODE_DISCARD));
        // Start and end ticks saturate near the top of the range.
        send_request(pack_request(TIME_MAX, 8'h44, 8'd77, 16'hFFFF, 4, 16'hFFFF,
                                  esa_pkg::MODE_DISCARD));
        send_request(pack_request(TIME_MAX - 100, 8'h45, 8'd77, 50, 4, 16'hFFFF,
                                  esa_pkg::MODE_DISCARD));
        send_request(pack_request(TIME_MAX - 1, 8'h46, 8'd77, 16'hFFFF, 4, 7,
                                  esa_pkg::MODE_DISCARD));
        send_request(pack_request(TIME_MAX - 1, 8'h47, 8'd77, 16'hFFFF, 4, 7,
                                  esa_pkg::MODE_DISCARD));
        // Equal values and equal end ticks must resolve to the lowest slot.
        send_request(pack_request(TIME_MAX - 1, 8'h48, 8'd100, 16'hFFFF, 4, 7,
                                  esa_pkg::MODE_SMALLEST));
        send_request(pack_request(TIME_MAX - 1, 8'h49, 8'h10, 16'hFFFF, 4, 7,
                                  MODE_EARLIEST));
        // Replace the long-lived entries so later traffic sees a normal table.
        repeat (TABLE_SLOTS)
            send_request(pack_request(5000, 8'h50, 8'hFF, 0, 4, 1, esa_pkg::MODE_SMALLEST));
        wait_idle();
    endtask

    task automatic test_duration_register();
        stall_pct = 20;
        write_duration(16'd0);
        send_request(pack_request(9000, 8'h60, 8'h61, 3, 4, 0, MODE_EARLIEST));
        send_request(pack_request(9001, 8'h62, 8'h63, 0, 4, 0, esa_pkg::MODE_SMALLEST));
        wait_idle();
        write_duration(16'd1);
        send_request(pack_request(9100, 8'h64, 8'h65, 0, 4, 0, esa_pkg::MODE_DISCARD));
        send_request(pack_request(9100, 8'h66, 8'h67, 4, 2, 0, MODE_EARLIEST));
        wait_idle();
        write_duration(16'hFFFF);
        send_request(pack_request(9200, 8'h68, 8'h69, 0, 4, 0, esa_pkg::MODE_DISCARD));
        send_request(pack_request(TIME_MAX - 70000, 8'h6A, 8'h6B, 16'hFFFF, 4, 0,
                                  MODE_EARLIEST));
        wait_idle();
        write_duration(esa_pkg::DELTA_W'($urandom_range(65535)));
        send_request(pack_request(9300, 8'h6C, 8'h6D, 0, 0, 0, esa_pkg::MODE_SMALLEST));
        wait_idle();
    endtask

    task automatic run_traffic_phase(input int unsigned stall_level,
                                     input logic [esa_pkg::DELTA_W-1:0] duration,
                                     input int count);
        write_duration(duration);
        stall_pct = stall_level;
        repeat (count)
            send_request(random_request());
        wait_idle();
    endtask

    task automatic test_random_traffic();
        tick_now = 10000;
        run_traffic_phase(0, esa_pkg::DEFAULT_DURATION_RESET, 385);
        run_traffic_phase(25, esa_pkg::DELTA_W'($urandom_range(65535)), 385);
        run_traffic_phase(60, 16'd1, 385);
        run_traffic_phase(85, 16'hFFFF, 385);
    endtask

    // The receiver holds its stall decision for a random run of cycles.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_now = ($urandom_range(99) < stall_pct);
            stall_left = $urandom_range(8, 1);
        end
        stall_left--;
        out_stall <= stall_now;
    end

    always @(posedge clk)
    begin : check_result
        alloc_result_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending");
                fail_count++;
            end
            else
            begin
                due = pending_results.pop_front();
                if (accepted !== due.written)
                begin
                    $error("accepted: expected %0d, got %0d", due.written, accepted);
                    fail_count++;
                end
                if (slot_written !== due.slot)
                begin
                    $error("slot_written: expected %0d, got %0d", due.slot, slot_written);
                    fail_count++;
                end
                if (end_time !== due.t_end)
                begin
                    $error("end_time: expected %0d, got %0d", due.t_end, end_time);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_duration_register();
        test_random_traffic();
        $display("Checked %0d requests: %0d written and %0d dropped.",
                 n_requests, n_written, n_dropped);
        $display("The default duration was written %0d times, from 0 up to 65535.",
                 n_cfg_writes);
        if (fail_count == 0)
            $display("expiring_slot_allocator_tb OK");
        else
            $display("expiring_slot_allocator_tb NOT OK");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("expiring_slot_allocator_tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/esa_pkg.sv
rtl/expiring_slot_allocator.sv
dv/expiring_slot_allocator_tb.sv
